@@ design/dag_topological_order_top_defines.svh @@
// Assertion macros used by the checker of the topological sort block
`ifndef DAG_TOPOLOGICAL_ORDER_TOP_DEFINES_SVH
`define DAG_TOPOLOGICAL_ORDER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define DAGTO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define DAGTO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/dagto_pkg.sv @@
// Shared constants, types and codes of the topological sort block
`timescale 1ns / 1ps
`default_nettype none

package dagto_pkg;

	localparam int MAX_NODES = 64;
	localparam int MAX_EDGES = 4096;

	// fixed field widths
	localparam int FLD_NODE_W   = 6;
	localparam int NODE_COUNT_W = 7;

	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int CNT_W   = NODE_W + 1;
	localparam int EADDR_W = $clog2(MAX_EDGES);
	localparam int EPTR_W  = EADDR_W + 1;
	localparam int DEG_W   = EPTR_W;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam logic [CFG_AW-3:0] REG_NODE_COUNT = '0;
	localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = NODE_COUNT_W'(64);

	// item actions
	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_START = 1'b1;

	typedef logic [NODE_W-1:0]     node_t;
	typedef logic [FLD_NODE_W-1:0] fnode_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [EADDR_W-1:0]    eaddr_t;
	typedef logic [EPTR_W-1:0]     eptr_t;
	typedef logic [DEG_W-1:0]      deg_t;

	localparam eptr_t EDGE_EMPTY = EPTR_W'(MAX_EDGES);

	// requests from the sequencer to the graph store
	typedef struct packed {
		logic   deg_rd;
		node_t  deg_raddr;
		logic   deg_we;
		node_t  deg_waddr;
		deg_t   deg_wdata;
		logic   head_rd;
		node_t  head_raddr;
		logic   head_we;
		node_t  head_waddr;
		eptr_t  head_wdata;
		logic   edge_rd;
		eaddr_t edge_raddr;
		logic   edge_we;
		eaddr_t edge_waddr;
		node_t  tgt_wdata;
		eptr_t  next_wdata;
		logic   fifo_rd;
		node_t  fifo_raddr;
		logic   fifo_we;
		node_t  fifo_waddr;
		node_t  fifo_wdata;
		logic   clear;
	} store_cmd_t;

	// registered read data, valid in the cycle after the request
	typedef struct packed {
		deg_t  deg;
		eptr_t head;
		node_t tgt;
		eptr_t nxt;
		node_t fifo;
	} store_rsp_t;

endpackage

`default_nettype wire

@@ design/dagto_chan_if.sv @@
// Valid/ready channel interfaces for edge/start items and order results
`timescale 1ns / 1ps
`default_nettype none

interface dagto_item_if import dagto_pkg::*;;
	logic   valid;
	logic   ready;
	logic   action;
	fnode_t before_node;
	fnode_t after_node;

	modport source (output valid, output action, output before_node, output after_node,
		input ready);
	modport sink (input valid, input action, input before_node, input after_node,
		output ready);
endinterface

interface dagto_result_if import dagto_pkg::*;;
	logic   valid;
	logic   ready;
	fnode_t node;
	logic   node_valid;
	logic   is_last;
	logic   complete;
	logic   edges_dropped;

	modport source (output valid, output node, output node_valid, output is_last,
		output complete, output edges_dropped, input ready);
	modport sink (input valid, input node, input node_valid, input is_last,
		input complete, input edges_dropped, output ready);
endinterface

`default_nettype wire

@@ design/dagto_store.sv @@
// Graph store: in-degrees, list heads, edge lists and the ready queue
`timescale 1ns / 1ps
`default_nettype none

module dagto_store import dagto_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  store_cmd_t cmd,
	output store_rsp_t rsp
);

	deg_t  deg_mem  [MAX_NODES];
	eptr_t head_mem [MAX_NODES];
	node_t tgt_mem  [MAX_EDGES];
	eptr_t nxt_mem  [MAX_EDGES];
	node_t fifo_mem [MAX_NODES];

	deg_t  deg_rd_q;
	eptr_t head_rd_q;
	node_t tgt_rd_q;
	eptr_t nxt_rd_q;
	node_t fifo_rd_q;

	// per-entry valid bits stand in for the reset/clear of the node tables
	logic [MAX_NODES-1:0] deg_vld_q;
	logic [MAX_NODES-1:0] head_vld_q;
	logic                 deg_rvld_q;
	logic                 head_rvld_q;

	always_ff @(posedge clk) begin
		if (cmd.deg_we)
			deg_mem[cmd.deg_waddr] <= cmd.deg_wdata;
		if (cmd.deg_rd)
			deg_rd_q <= deg_mem[cmd.deg_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.head_we)
			head_mem[cmd.head_waddr] <= cmd.head_wdata;
		if (cmd.head_rd)
			head_rd_q <= head_mem[cmd.head_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.edge_we) begin
			tgt_mem[cmd.edge_waddr] <= cmd.tgt_wdata;
			nxt_mem[cmd.edge_waddr] <= cmd.next_wdata;
		end
		if (cmd.edge_rd) begin
			tgt_rd_q <= tgt_mem[cmd.edge_raddr];
			nxt_rd_q <= nxt_mem[cmd.edge_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fifo_we)
			fifo_mem[cmd.fifo_waddr] <= cmd.fifo_wdata;
		if (cmd.fifo_rd)
			fifo_rd_q <= fifo_mem[cmd.fifo_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_vld_q   <= '0;
			head_vld_q  <= '0;
			deg_rvld_q  <= 1'b0;
			head_rvld_q <= 1'b0;
		end else if (cmd.clear) begin
			deg_vld_q  <= '0;
			head_vld_q <= '0;
		end else begin
			if (cmd.deg_we)
				deg_vld_q[cmd.deg_waddr] <= 1'b1;
			if (cmd.head_we)
				head_vld_q[cmd.head_waddr] <= 1'b1;
			if (cmd.deg_rd)
				deg_rvld_q <= deg_vld_q[cmd.deg_raddr];
			if (cmd.head_rd)
				head_rvld_q <= head_vld_q[cmd.head_raddr];
		end
	end

	always_comb begin
		rsp.deg  = deg_rvld_q ? deg_rd_q : '0;
		rsp.head = head_rvld_q ? head_rd_q : EDGE_EMPTY;
		rsp.tgt  = tgt_rd_q;
		rsp.nxt  = nxt_rd_q;
		rsp.fifo = fifo_rd_q;
	end

endmodule

`default_nettype wire

@@ design/dag_topological_order_top.sv @@
// An edge add is a store read-modify-write; ready drops while the write is done.
// Start scans the in-degree of each of N nodes, N the node count held to 1..64, queues
// those at zero, then dequeues each node, emits it and walks its edges; a node goes out
// once the next is dequeued or the run ends, and result stalls hold the walk.
// arst_n clears control state, node_count to 64 and the store's valid bits; edge
// memories are left unset and the store is emptied again after every run.
`timescale 1ns / 1ps
`default_nettype none

module dag_topological_order_top import dagto_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	dagto_item_if.sink          item,
	dagto_result_if.source      result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [CFG_DW-1:0]   pwdata,
	output logic [CFG_DW-1:0]   prdata,
	output logic                pready
);

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_ADD      = 11'b000_0000_0010,
		S_SCAN_RD  = 11'b000_0000_0100,
		S_SCAN_CHK = 11'b000_0000_1000,
		S_DEQ      = 11'b000_0001_0000,
		S_HEAD     = 11'b000_0010_0000,
		S_EMIT     = 11'b000_0100_0000,
		S_EDGE_RD  = 11'b000_1000_0000,
		S_EDGE_T   = 11'b001_0000_0000,
		S_EDGE_UPD = 11'b010_0000_0000,
		S_DONE     = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic [NODE_COUNT_W-1:0] node_count_q;
	logic [NODE_COUNT_W-1:0] n_eff;

	fnode_t item_b_q;
	fnode_t item_a_q;
	logic   add_ok_q;
	eptr_t  edge_cnt_q;
	logic   ovf_q;

	cnt_t  scan_q;
	cnt_t  qhead_q;
	cnt_t  qtail_q;
	node_t cur_q;
	node_t t_q;
	eptr_t e_q;
	node_t pend_node_q;
	logic  pend_vld_q;

	logic   res_vld_q;
	fnode_t res_node_q;
	logic   res_nvld_q;
	logic   res_last_q;
	logic   res_comp_q;
	logic   res_drop_q;

	store_cmd_t cmd;
	store_rsp_t rsp;

	logic  item_acc;
	logic  out_free;
	logic  res_load;
	logic  edge_full;
	logic  in_range;
	logic  deg_zero;
	deg_t  deg_adj;
	logic  dec_ok;
	cnt_t  scan_nxt;
	logic  cfg_we;

	dagto_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	// configuration register
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[CFG_AW-1:2] == REG_NODE_COUNT);
	assign prdata = (paddr[CFG_AW-1:2] == REG_NODE_COUNT) ?
		CFG_DW'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			node_count_q <= NODE_COUNT_RST;
		else if (cfg_we)
			node_count_q <= pwdata[NODE_COUNT_W-1:0];
	end

	always_comb begin
		if (node_count_q == '0)
			n_eff = NODE_COUNT_W'(1);
		else if (node_count_q > NODE_COUNT_W'(MAX_NODES))
			n_eff = NODE_COUNT_W'(MAX_NODES);
		else
			n_eff = node_count_q;
	end

	assign item.ready = (state_q == S_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign out_free   = !res_vld_q || result.ready;
	assign res_load   = out_free && (((state_q == S_EMIT) && pend_vld_q) || (state_q == S_DONE));
	assign edge_full  = (edge_cnt_q == EPTR_W'(MAX_EDGES));
	assign in_range   = ({1'b0, item.before_node} < n_eff) && ({1'b0, item.after_node} < n_eff);
	assign scan_nxt   = scan_q + CNT_W'(1);

	// shared in-degree unit: increment on edge add, decrement while walking
	assign deg_zero = (rsp.deg == '0);
	assign deg_adj  = rsp.deg + ((state_q == S_ADD) ? DEG_W'(1) : '1);
	assign dec_ok   = (NODE_COUNT_W'(t_q) < n_eff) && !deg_zero;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.head_rd    = item_acc;
				cmd.head_raddr = item.before_node[NODE_W-1:0];
				cmd.deg_rd     = item_acc;
				cmd.deg_raddr  = item.after_node[NODE_W-1:0];
			end
			S_ADD: begin
				if (add_ok_q && !edge_full) begin
					cmd.edge_we    = 1'b1;
					cmd.edge_waddr = edge_cnt_q[EADDR_W-1:0];
					cmd.tgt_wdata  = item_a_q[NODE_W-1:0];
					cmd.next_wdata = rsp.head;
					cmd.head_we    = 1'b1;
					cmd.head_waddr = item_b_q[NODE_W-1:0];
					cmd.head_wdata = edge_cnt_q;
					cmd.deg_we     = 1'b1;
					cmd.deg_waddr  = item_a_q[NODE_W-1:0];
					cmd.deg_wdata  = deg_adj;
				end
			end
			S_SCAN_RD: begin
				cmd.deg_rd    = 1'b1;
				cmd.deg_raddr = scan_q[NODE_W-1:0];
			end
			S_SCAN_CHK: begin
				cmd.fifo_we    = deg_zero;
				cmd.fifo_waddr = qtail_q[NODE_W-1:0];
				cmd.fifo_wdata = scan_q[NODE_W-1:0];
			end
			S_DEQ: begin
				cmd.fifo_rd    = (qhead_q != qtail_q);
				cmd.fifo_raddr = qhead_q[NODE_W-1:0];
			end
			S_HEAD: begin
				cmd.head_rd    = 1'b1;
				cmd.head_raddr = rsp.fifo;
			end
			S_EMIT: begin
			end
			S_EDGE_RD: begin
				cmd.edge_rd    = (e_q != EDGE_EMPTY);
				cmd.edge_raddr = e_q[EADDR_W-1:0];
			end
			S_EDGE_T: begin
				cmd.deg_rd    = 1'b1;
				cmd.deg_raddr = rsp.tgt;
			end
			S_EDGE_UPD: begin
				cmd.deg_we     = dec_ok;
				cmd.deg_waddr  = t_q;
				cmd.deg_wdata  = deg_adj;
				cmd.fifo_we    = dec_ok && (rsp.deg == DEG_W'(1));
				cmd.fifo_waddr = qtail_q[NODE_W-1:0];
				cmd.fifo_wdata = t_q;
			end
			S_DONE: begin
				cmd.clear = out_free;
			end
			default: begin
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				item_b_q <= item.before_node;
				item_a_q <= item.after_node;
				add_ok_q <= in_range;
			end
			S_HEAD:
				cur_q <= rsp.fifo;
			S_EMIT:
				if (out_free) begin
					pend_node_q <= cur_q;
					e_q         <= rsp.head;
				end
			S_EDGE_T: begin
				t_q <= rsp.tgt;
				e_q <= rsp.nxt;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			edge_cnt_q <= '0;
			ovf_q      <= 1'b0;
			scan_q     <= '0;
			qhead_q    <= '0;
			qtail_q    <= '0;
			pend_vld_q <= 1'b0;
			res_vld_q  <= 1'b0;
			res_node_q <= '0;
			res_nvld_q <= 1'b0;
			res_last_q <= 1'b0;
			res_comp_q <= 1'b0;
			res_drop_q <= 1'b0;
		end else begin
			if (res_load)
				res_vld_q <= 1'b1;
			else if (result.ready)
				res_vld_q <= 1'b0;
			case (state_q)
				S_IDLE:
					if (item_acc) begin
						if (item.action == ACT_START) begin
							scan_q  <= '0;
							qhead_q <= '0;
							qtail_q <= '0;
							state_q <= S_SCAN_RD;
						end else begin
							state_q <= S_ADD;
						end
					end
				S_ADD: begin
					if (add_ok_q) begin
						if (edge_full)
							ovf_q <= 1'b1;
						else
							edge_cnt_q <= edge_cnt_q + EPTR_W'(1);
					end
					state_q <= S_IDLE;
				end
				S_SCAN_RD:
					state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					if (deg_zero)
						qtail_q <= qtail_q + CNT_W'(1);
					scan_q <= scan_nxt;
					if (NODE_COUNT_W'(scan_nxt) == n_eff)
						state_q <= S_DEQ;
					else
						state_q <= S_SCAN_RD;
				end
				S_DEQ:
					if (qhead_q == qtail_q) begin
						state_q <= S_DONE;
					end else begin
						qhead_q <= qhead_q + CNT_W'(1);
						state_q <= S_HEAD;
					end
				S_HEAD:
					state_q <= S_EMIT;
				S_EMIT:
					if (out_free) begin
						// previous node goes out now that it is known not to be last
						if (pend_vld_q) begin
							res_node_q <= FLD_NODE_W'(pend_node_q);
							res_nvld_q <= 1'b1;
							res_last_q <= 1'b0;
							res_comp_q <= 1'b0;
							res_drop_q <= 1'b0;
						end
						pend_vld_q <= 1'b1;
						state_q    <= S_EDGE_RD;
					end
				S_EDGE_RD:
					if (e_q == EDGE_EMPTY)
						state_q <= S_DEQ;
					else
						state_q <= S_EDGE_T;
				S_EDGE_T:
					state_q <= S_EDGE_UPD;
				S_EDGE_UPD: begin
					if (dec_ok && (rsp.deg == DEG_W'(1)))
						qtail_q <= qtail_q + CNT_W'(1);
					state_q <= S_EDGE_RD;
				end
				S_DONE:
					if (out_free) begin
						res_node_q <= pend_vld_q ? FLD_NODE_W'(pend_node_q) : '0;
						res_nvld_q <= pend_vld_q;
						res_last_q <= 1'b1;
						res_comp_q <= pend_vld_q && (NODE_COUNT_W'(qhead_q) == n_eff);
						res_drop_q <= ovf_q;
						pend_vld_q <= 1'b0;
						edge_cnt_q <= '0;
						ovf_q      <= 1'b0;
						state_q    <= S_IDLE;
					end
				default:
					state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid         = res_vld_q;
	assign result.node          = res_node_q;
	assign result.node_valid    = res_nvld_q;
	assign result.is_last       = res_last_q;
	assign result.complete      = res_comp_q;
	assign result.edges_dropped = res_drop_q;

endmodule

`default_nettype wire

@@ design/dagto_checker.sv @@
// Port-level checks of the topological sort block, bound to its top level
`timescale 1ns / 1ps
`default_nettype none

`include "dag_topological_order_top_defines.svh"

module dagto_checker import dagto_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	input wire logic   in_valid,
	input wire logic   in_ready,
	input wire logic   out_valid,
	input wire logic   out_ready,
	input wire fnode_t out_node,
	input wire logic   out_node_valid,
	input wire logic   out_is_last,
	input wire logic   out_complete,
	input wire logic   out_dropped
);

	// ready drops right after an item is taken, as every item keeps the block busy
	`DAGTO_ASSERT_NEXT(a_busy_after_item, in_valid && in_ready, !in_ready, "ready right after item")

	// run summary only on the final result
	`DAGTO_ASSERT_NOW(a_summary_on_last, out_valid && !out_is_last, !out_complete && !out_dropped, "summary bits on non-final result")

	// an empty result closes a run that emitted nothing
	`DAGTO_ASSERT_NOW(a_empty_is_last, out_valid && !out_node_valid, out_is_last && !out_complete && out_node == '0, "bad empty result")

	// a stalled result holds
	`DAGTO_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable({out_node, out_node_valid, out_is_last, out_complete, out_dropped}), "result changed under stall")

endmodule

bind dag_topological_order_top dagto_checker u_dagto_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (item.valid),
	.in_ready       (item.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.out_node       (result.node),
	.out_node_valid (result.node_valid),
	.out_is_last    (result.is_last),
	.out_complete   (result.complete),
	.out_dropped    (result.edges_dropped)
);

`default_nettype wire

@@ sim/dag_topological_order_top_test.sv @@
// Self-checking bench for the topological sort block with a Kahn-order predictor
`timescale 1ns / 1ps

module dag_topological_order_top_test;
	import dagto_pkg::*;

	localparam int CYCLE_LIMIT    = 800000;
	localparam int SETTLE_CYCLES  = 2 * MAX_NODES + 20;
	localparam int RANDOM_ITEMS   = 230;

	typedef struct packed {
		fnode_t node;
		logic   node_valid;
		logic   is_last;
		logic   complete;
		logic   edges_dropped;
	} order_rec_t;

	class topo_order_board;
		logic [NODE_COUNT_W-1:0] node_count_reg;
		deg_t        pred_count [MAX_NODES];
		eptr_t       succ_head  [MAX_NODES];
		fnode_t      succ_node  [MAX_EDGES];
		eptr_t       succ_link  [MAX_EDGES];
		int unsigned edges_held;
		logic        edge_lost;
		order_rec_t  expected_order [$];
		int          mismatches;

		function new();
			node_count_reg = NODE_COUNT_RST;
			mismatches = 0;
			clear_graph();
		endfunction

		function void clear_graph();
			for (int i = 0; i < MAX_NODES; i++) begin
				pred_count[i] = '0;
				succ_head[i] = EDGE_EMPTY;
			end
			edges_held = 0;
			edge_lost = 1'b0;
		endfunction

		// 0 acts as 1, anything above the node limit as the limit
		function int unsigned live_nodes();
			if (node_count_reg == 0) return 1;
			if (node_count_reg > MAX_NODES) return MAX_NODES;
			return node_count_reg;
		endfunction

		function void note_item(logic act, fnode_t src, fnode_t dst);
			int unsigned n;
			n = live_nodes();
			if (act == ACT_START) begin
				kahn_order(n);
				return;
			end
			if (src >= n || dst >= n) return;
			if (edges_held >= MAX_EDGES) begin
				edge_lost = 1'b1;
				return;
			end
			// newest edge goes to the head of the list
			succ_node[edges_held] = dst;
			succ_link[edges_held] = succ_head[src];
			succ_head[src] = eptr_t'(edges_held);
			edges_held++;
			pred_count[dst]++;
		endfunction

		function void kahn_order(int unsigned n);
			int unsigned ready_q [$];
			order_rec_t  run_out [$];
			order_rec_t  rec;
			int unsigned cur, tgt, emitted, guard;
			eptr_t       e;
			emitted = 0;
			for (int unsigned i = 0; i < n; i++)
				if (pred_count[i] == 0) ready_q = {ready_q, i};
			while (ready_q.size() != 0 && emitted < n) begin
				cur = ready_q.pop_front();
				rec = '0;
				rec.node = fnode_t'(cur);
				rec.node_valid = 1'b1;
				run_out = {run_out, rec};
				emitted++;
				e = succ_head[cur];
				guard = 0;
				while (e < MAX_EDGES && guard < MAX_EDGES) begin
					tgt = succ_node[e];
					// targets beyond a lowered count are skipped
					if (tgt < n && pred_count[tgt] > 0) begin
						pred_count[tgt]--;
						if (pred_count[tgt] == 0 && ready_q.size() < MAX_NODES)
							ready_q = {ready_q, tgt};
					end
					e = succ_link[e];
					guard++;
				end
			end
			if (run_out.size() == 0) begin
				rec = '0;
				run_out = {run_out, rec};
			end
			rec = run_out[run_out.size() - 1];
			rec.is_last = 1'b1;
			rec.complete = (emitted == n);
			rec.edges_dropped = edge_lost;
			run_out[run_out.size() - 1] = rec;
			expected_order = {expected_order, run_out};
			clear_graph();
		endfunction

		task note_mismatch(string what, int got_v, int want_v);
			mismatches++;
			$display("%0t mismatch %s: got %0d, want %0d", $time, what, got_v, want_v);
		endtask

		task check_result(order_rec_t got);
			order_rec_t want;
			if (expected_order.size() == 0) begin
				note_mismatch("result with nothing expected, node", got.node, -1);
				return;
			end
			want = expected_order.pop_front();
			if (got.node != want.node) note_mismatch("node", got.node, want.node);
			if (got.node_valid != want.node_valid)
				note_mismatch("node_valid", got.node_valid, want.node_valid);
			if (got.is_last != want.is_last) note_mismatch("is_last", got.is_last, want.is_last);
			if (got.complete != want.complete)
				note_mismatch("complete", got.complete, want.complete);
			if (got.edges_dropped != want.edges_dropped)
				note_mismatch("edges_dropped", got.edges_dropped, want.edges_dropped);
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;

	dagto_item_if   item_ch ();
	dagto_result_if result_ch ();

	topo_order_board board;
	int              stim_items;
	int              cycle_count = 0;
	logic            calm;

	dag_topological_order_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin : watch_results
		order_rec_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.node = result_ch.node;
			got.node_valid = result_ch.node_valid;
			got.is_last = result_ch.is_last;
			got.complete = result_ch.complete;
			got.edges_dropped = result_ch.edges_dropped;
			board.check_result(got);
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [NODE_COUNT_W-1:0] pick_node_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return NODE_COUNT_W'($urandom_range(MAX_NODES + 1, 127));
			2: return NODE_COUNT_W'(127);
			3: return NODE_COUNT_W'(MAX_NODES);
			4: return NODE_COUNT_W'(1);
			default: return NODE_COUNT_W'($urandom_range(1, MAX_NODES));
		endcase
	endfunction

	// result-side stalls; calm stretches turn off idling on both sides
	initial begin
		int stall;
		stall = 0;
		calm = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 299) == 0) calm = !calm;
			if (stall > 0) begin
				result_ch.ready = 1'b0;
				stall--;
			end else begin
				result_ch.ready = 1'b1;
				if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
			end
		end
	end

	task automatic send_item(logic act, fnode_t src, fnode_t dst);
		int          gap;
		int unsigned n;
		gap = calm ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.action = act;
		item_ch.before_node = src;
		item_ch.after_node = dst;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		n = board.live_nodes();
		if (act == ACT_START || (src < n && dst < n)) stim_items++;
		board.note_item(act, src, dst);
	endtask

	task automatic hold_items();
		@(negedge clk);
		item_ch.valid = 1'b0;
	endtask

	task automatic drain_results();
		while (board.expected_order.size() != 0) @(posedge clk);
	endtask

	task automatic write_node_count(logic [NODE_COUNT_W-1:0] value);
		hold_items();
		drain_results();
		// wait before the write; the store was cleared as the last result was loaded
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = CFG_AW'({REG_NODE_COUNT, 2'b00});
		pwdata = CFG_DW'(value);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.node_count_reg = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// acyclic edges over a shuffled order, some noise, sometimes a cycle or a lowered count, then start
	task automatic send_graph_set();
		int perm [MAX_NODES];
		int n, edges, i, j, tmp;
		n = board.live_nodes();
		for (int k = 0; k < n; k++) perm[k] = k;
		for (int k = n - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = perm[k];
			perm[k] = perm[j];
			perm[j] = tmp;
		end
		edges = $urandom_range(0, (n < 8) ? 2 * n : 16);
		for (int k = 0; k < edges; k++) begin
			if (n == 1 || $urandom_range(0, 9) == 0) begin
				send_item(ACT_ADD, fnode_t'($urandom_range(0, 63)), fnode_t'($urandom_range(0, 63)));
			end else begin
				i = $urandom_range(0, n - 2);
				j = $urandom_range(i + 1, n - 1);
				send_item(ACT_ADD, fnode_t'(perm[i]), fnode_t'(perm[j]));
			end
		end
		if (n > 1 && $urandom_range(0, 7) == 0) begin
			i = $urandom_range(0, n - 2);
			j = $urandom_range(i + 1, n - 1);
			send_item(ACT_ADD, fnode_t'(perm[j]), fnode_t'(perm[i]));
		end
		// count lowered while edges are held
		if (n > 1 && $urandom_range(0, 9) == 0)
			write_node_count(NODE_COUNT_W'($urandom_range(1, n - 1)));
		send_item(ACT_START, fnode_t'($urandom_range(0, 63)), fnode_t'($urandom_range(0, 63)));
	endtask

	initial begin
		int set_no;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.action = ACT_ADD;
		item_ch.before_node = '0;
		item_ch.after_node = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		board = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset count, duplicate edge, extreme node numbers
		send_item(ACT_ADD, 6'd63, 6'd0);
		send_item(ACT_ADD, 6'd0, 6'd62);
		send_item(ACT_ADD, 6'd63, 6'd62);
		send_item(ACT_ADD, 6'd0, 6'd62);
		send_item(ACT_START, 6'd63, 6'd63);

		// count 0 acts as one node: unused-node edge, then a self loop blocking everything
		write_node_count('0);
		send_item(ACT_ADD, 6'd1, 6'd0);
		send_item(ACT_START, 6'd0, 6'd0);
		send_item(ACT_ADD, 6'd0, 6'd0);
		send_item(ACT_START, 6'd0, 6'd0);

		// count above the limit, two-node cycle
		write_node_count(NODE_COUNT_W'(127));
		send_item(ACT_ADD, 6'd5, 6'd6);
		send_item(ACT_ADD, 6'd6, 6'd5);
		send_item(ACT_ADD, 6'd0, 6'd5);
		send_item(ACT_ADD, 6'd63, 6'd7);
		send_item(ACT_START, 6'd21, 6'd42);

		// edges held across a lower count; node 3 stays blocked by node 40
		write_node_count(NODE_COUNT_W'(64));
		send_item(ACT_ADD, 6'd10, 6'd20);
		send_item(ACT_ADD, 6'd20, 6'd30);
		send_item(ACT_ADD, 6'd40, 6'd3);
		send_item(ACT_ADD, 6'd3, 6'd11);
		write_node_count(NODE_COUNT_W'(25));
		send_item(ACT_START, 6'd42, 6'd21);

		stim_items = 0;
		set_no = 0;
		while (stim_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0) write_node_count(pick_node_count());
			send_graph_set();
			if (set_no == 0 || $urandom_range(0, 3) == 0) begin
				hold_items();
				drain_results();
			end
			set_no++;
		end

		hold_items();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/dagto_pkg.sv
design/dagto_chan_if.sv
design/dagto_store.sv
design/dag_topological_order_top.sv
design/dagto_checker.sv
sim/dag_topological_order_top_test.sv
